[sv/assert_macros.svh]
// Assertion helper macros for the pad hit cluster builder RTL.
// Each macro expects signals clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[sv/phcb_pkg.sv]
// Shared types and constants of the pad hit cluster builder.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package phcb_pkg;

  // Cluster store depth and derived widths
  localparam int MAX_HITS = 64;
  localparam int IDX_W    = $clog2(MAX_HITS);
  localparam int CNT_W    = $clog2(MAX_HITS + 1);

  // Fixed field widths
  localparam int CH_W  = 8;
  localparam int PAD_W = 7;
  localparam int POS_W = 16;
  localparam int HIT_W = 7;

  // Exact position sums: one sign bit plus enough growth for MAX_HITS terms
  localparam int SUM_W = POS_W + IDX_W + 1;

  // Request codes
  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_APPEND = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_APART  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    logic                    req_type;
    logic [CH_W-1:0]         chamber;
    logic [PAD_W-1:0]        pad_i;
    logic [PAD_W-1:0]        pad_j;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } hit_item_t;

  typedef struct packed {
    status_t                 status;
    logic [HIT_W-1:0]        hit_count;
    logic signed [POS_W-1:0] centroid_x;
    logic signed [POS_W-1:0] centroid_y;
  } res_item_t;

endpackage

`default_nettype wire

[sv/phcb_chan_if.sv]
// Valid/ready channel interfaces for hit items and result items.
// Depends on phcb_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface phcb_hit_if;
  logic                 valid;
  logic                 ready;
  phcb_pkg::hit_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface phcb_res_if;
  logic                 valid;
  logic                 ready;
  phcb_pkg::res_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/pad_hit_cluster_builder.sv]
// Pad hit cluster builder: top level with pad store, scan and shared divider.
// Depends on phcb_pkg, phcb_chan_if.sv and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Builds one cluster of pad hits. A start item resets the cluster to its hit;
// an append item joins if it is in the cluster's chamber and within one pad
// in both i and j of some stored hit. Every item yields one result with the
// status, hit count and centroid (sums divided by count, truncated toward
// zero). The block takes one item at a time: hit.ready is high only while
// idle. A start or rejected append goes straight to the one-bit-per-cycle
// restoring divider, which is used first for x and then for y; the result
// is loaded into the output register from S_DONE once that register is
// free. An append that passes the chamber check first runs the adjacency
// scan, which reads the pad store one entry per cycle and stops on the
// first neighbor or after the last stored hit. A finished result waits in
// the output register while the next item is accepted and processed.
module pad_hit_cluster_builder (
  input  wire logic  clk,
  input  wire logic  rst,
  phcb_hit_if.sink   hit,
  phcb_res_if.source result
);
  import phcb_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SCAN    = 5'b00010,
    S_DIV_LD  = 5'b00100,
    S_DIV_RUN = 5'b01000,
    S_DONE    = 5'b10000
  } state_t;

  state_t                  state;

  // Cluster state
  logic [CH_W-1:0]         cluster_chamber;
  logic [CNT_W-1:0]        count;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;

  // Item being processed
  hit_item_t               item;
  status_t                 status;

  // Scan control
  logic [CNT_W-1:0]        scan_idx;
  logic                    cmp_vld;

  // Divider
  logic                    div_axis;
  logic                    div_neg;
  logic [SUM_W-1:0]        quo;
  logic [CNT_W-1:0]        rem;
  logic [STEP_W-1:0]       step;
  logic signed [POS_W-1:0] cent_x;
  logic signed [POS_W-1:0] cent_y;

  // Output register
  logic                    res_valid;
  res_item_t               res_data;

  // Pad store
  logic [2*PAD_W-1:0]      pad_mem [MAX_HITS];
  logic [2*PAD_W-1:0]      rd_data;
  logic                    pad_we;
  logic [IDX_W-1:0]        pad_wa;
  logic [2*PAD_W-1:0]      pad_wd;
  logic                    pad_re;
  logic [IDX_W-1:0]        pad_ra;

  function automatic logic pad_near(input logic [PAD_W-1:0] a, input logic [PAD_W-1:0] b);
    logic [PAD_W:0] d;
    d = {1'b0, a} - {1'b0, b};
    return (d == '0) || (d == (PAD_W+1)'(1)) || (d == '1);
  endfunction

  // Handshake
  logic hit_acc;
  logic res_free;
  logic res_load;
  assign hit.ready     = (state == S_IDLE);
  assign hit_acc       = hit.valid && hit.ready;
  assign res_free      = !res_valid || result.ready;
  assign res_load      = (state == S_DONE) && res_free;
  assign result.valid  = res_valid;
  assign result.data   = res_data;

  // Accept-cycle decisions
  logic start_req;
  logic quick_reject;
  assign start_req    = (hit.data.req_type == REQ_START);
  assign quick_reject = (count == '0) || (hit.data.chamber != cluster_chamber);

  // Scan: issue one store read per cycle, compare the registered entry
  logic scan_issue;
  logic scan_hit;
  logic scan_end;
  logic store_full;
  assign scan_issue = (state == S_SCAN) && (scan_idx < count);
  assign scan_hit   = (state == S_SCAN) && cmp_vld &&
                      pad_near(item.pad_i, rd_data[2*PAD_W-1:PAD_W]) &&
                      pad_near(item.pad_j, rd_data[PAD_W-1:0]);
  assign scan_end   = (state == S_SCAN) && !cmp_vld && !scan_issue;
  assign store_full = (count == CNT_W'(MAX_HITS));

  // Store port selection
  always_comb begin
    pad_re = scan_issue;
    pad_ra = scan_idx[IDX_W-1:0];
    if (state == S_IDLE) begin
      pad_we = hit_acc && start_req;
      pad_wa = '0;
      pad_wd = {hit.data.pad_i, hit.data.pad_j};
    end else begin
      pad_we = scan_hit && !store_full;
      pad_wa = count[IDX_W-1:0];
      pad_wd = {item.pad_i, item.pad_j};
    end
  end

  always_ff @(posedge clk) begin
    if (pad_we) begin
      pad_mem[pad_wa] <= pad_wd;
    end
    if (pad_re) begin
      rd_data <= pad_mem[pad_ra];
    end
  end

  // Shared divider step: restoring, one quotient bit per cycle
  logic signed [SUM_W-1:0] sum_sel;
  logic [SUM_W-1:0]        sum_mag;
  logic [CNT_W:0]          rem_sh;
  logic                    div_ge;
  logic [CNT_W-1:0]        rem_step;
  logic [SUM_W-1:0]        quo_step;
  logic [SUM_W-1:0]        quo_fix;
  logic signed [POS_W-1:0] mean;
  always_comb begin
    sum_sel  = div_axis ? sum_y : sum_x;
    sum_mag  = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
    rem_sh   = {rem, quo[SUM_W-1]};
    div_ge   = (rem_sh >= {1'b0, count});
    rem_step = div_ge ? CNT_W'(rem_sh - {1'b0, count}) : rem_sh[CNT_W-1:0];
    quo_step = {quo[SUM_W-2:0], div_ge};
    quo_fix  = div_neg ? SUM_W'(SUM_W'(0) - quo_step) : quo_step;
    mean     = (count == '0) ? '0 : $signed(quo_fix[POS_W-1:0]);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      cluster_chamber <= '0;
      count           <= '0;
      sum_x           <= '0;
      sum_y           <= '0;
      cmp_vld         <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      // Output item held until taken, reloaded when a result finishes
      res_valid <= res_load || (res_valid && !result.ready);
      unique case (state)
        S_IDLE: begin
          if (hit_acc) begin
            item     <= hit.data;
            div_axis <= 1'b0;
            scan_idx <= '0;
            cmp_vld  <= 1'b0;
            if (start_req) begin
              cluster_chamber <= hit.data.chamber;
              count           <= CNT_W'(1);
              sum_x           <= SUM_W'($signed(hit.data.pos_x));
              sum_y           <= SUM_W'($signed(hit.data.pos_y));
              status          <= ST_OK;
              state           <= S_DIV_LD;
            end else if (quick_reject) begin
              status <= ST_REJECT;
              state  <= S_DIV_LD;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          cmp_vld  <= scan_issue && !scan_hit;
          scan_idx <= scan_idx + CNT_W'(scan_issue);
          if (scan_hit) begin
            state <= S_DIV_LD;
            if (store_full) begin
              status <= ST_FULL;
            end else begin
              status <= ST_OK;
              count  <= count + CNT_W'(1);
              sum_x  <= sum_x + SUM_W'($signed(item.pos_x));
              sum_y  <= sum_y + SUM_W'($signed(item.pos_y));
            end
          end else if (scan_end) begin
            status <= ST_APART;
            state  <= S_DIV_LD;
          end
        end
        S_DIV_LD: begin
          quo     <= sum_mag;
          div_neg <= sum_sel[SUM_W-1];
          rem     <= '0;
          step    <= STEP_W'(SUM_W - 1);
          state   <= S_DIV_RUN;
        end
        S_DIV_RUN: begin
          quo  <= quo_step;
          rem  <= rem_step;
          step <= step - STEP_W'(1);
          if (step == '0) begin
            if (!div_axis) begin
              cent_x   <= mean;
              div_axis <= 1'b1;
              state    <= S_DIV_LD;
            end else begin
              cent_y <= mean;
              state  <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (res_free) begin
            res_data.status     <= status;
            res_data.hit_count  <= HIT_W'(count);
            res_data.centroid_x <= cent_x;
            res_data.centroid_y <= cent_y;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  `ASSERT_IMPL(a_count_bound, 1'b1, count <= CNT_W'(MAX_HITS))
  `ASSERT_IMPL(a_scan_bound, state == S_SCAN, scan_idx <= count)
  `ASSERT_IMPL(a_full_status, res_load && (status == ST_FULL), store_full)
  `ASSERT_NEXT(a_ok_nonempty, res_load && (status == ST_OK),
               res_valid && (res_data.hit_count != '0))

endmodule

`default_nettype wire

[tb/pad_hit_cluster_builder_test.sv]
// Self-checking testbench for pad_hit_cluster_builder: directed and random hit items.
// Depends on phcb_pkg, phcb_chan_if.sv and the pad_hit_cluster_builder RTL.
`timescale 1ns / 1ps

module pad_hit_cluster_builder_test;
  import phcb_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 150;
  localparam int PHASE_ITEMS = 270;

  logic clk;
  logic rst;

  phcb_hit_if hit_ch ();
  phcb_res_if res_ch ();

  pad_hit_cluster_builder uut (
    .clk    (clk),
    .rst    (rst),
    .hit    (hit_ch),
    .result (res_ch)
  );

  // Cluster state as seen by the predictor
  logic [CH_W-1:0]  clu_chamber;
  logic [PAD_W-1:0] clu_pad_i [MAX_HITS];
  logic [PAD_W-1:0] clu_pad_j [MAX_HITS];
  int               clu_count;
  longint           clu_sum_x;
  longint           clu_sum_y;

  res_item_t pending_results[$];
  int        mismatches;
  int        cycle_count;
  int        send_gap_pct;
  int        recv_stall_pct;

  // Clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver back-pressure, changed on the falling edge
  always @(negedge clk) begin
    res_ch.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Centroid of a running sum, truncated toward zero
  function automatic logic signed [POS_W-1:0] mean_pos(longint sum, int n);
    longint q;
    if (n == 0) return '0;
    q = sum / longint'(n);
    return q[POS_W-1:0];
  endfunction

  // Apply one hit item to the cluster and return the result it yields
  function automatic res_item_t cluster_predict(hit_item_t h);
    res_item_t r;
    status_t   st;
    bit        near;
    int        di;
    int        dj;
    near = 1'b0;
    if (h.req_type == REQ_START) begin
      clu_chamber  = h.chamber;
      clu_pad_i[0] = h.pad_i;
      clu_pad_j[0] = h.pad_j;
      clu_count    = 1;
      clu_sum_x    = longint'(h.pos_x);
      clu_sum_y    = longint'(h.pos_y);
      st           = ST_OK;
    end else if (clu_count == 0 || h.chamber != clu_chamber) begin
      st = ST_REJECT;
    end else begin
      for (int k = 0; k < clu_count && !near; k++) begin
        di = int'(h.pad_i) - int'(clu_pad_i[k]);
        dj = int'(h.pad_j) - int'(clu_pad_j[k]);
        if (di >= -1 && di <= 1 && dj >= -1 && dj <= 1) near = 1'b1;
      end
      if (!near) begin
        st = ST_APART;
      end else if (clu_count >= MAX_HITS) begin
        st = ST_FULL;
      end else begin
        clu_pad_i[clu_count] = h.pad_i;
        clu_pad_j[clu_count] = h.pad_j;
        clu_count++;
        clu_sum_x += longint'(h.pos_x);
        clu_sum_y += longint'(h.pos_y);
        st = ST_OK;
      end
    end
    r.status     = st;
    r.hit_count  = clu_count[HIT_W-1:0];
    r.centroid_x = mean_pos(clu_sum_x, clu_count);
    r.centroid_y = mean_pos(clu_sum_y, clu_count);
    return r;
  endfunction

  function automatic hit_item_t make_hit(logic req, logic [CH_W-1:0] ch, int pi, int pj,
                                         logic signed [POS_W-1:0] x,
                                         logic signed [POS_W-1:0] y);
    hit_item_t h;
    h.req_type = req;
    h.chamber  = ch;
    h.pad_i    = pi[PAD_W-1:0];
    h.pad_j    = pj[PAD_W-1:0];
    h.pos_x    = x;
    h.pos_y    = y;
    return h;
  endfunction

  // Pad within one step of p, kept inside the pad range
  function automatic int near_pad(logic [PAD_W-1:0] p);
    int v;
    v = int'(p) + int'($urandom_range(2)) - 1;
    if (v < 0) v = 0;
    if (v > 127) v = 127;
    return v;
  endfunction

  // Random position, weighted toward the extremes
  function automatic logic signed [POS_W-1:0] rand_pos();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return r[POS_W-1:0];
    endcase
  endfunction

  // Drive one item on the falling edge and hold it until accepted
  task automatic send_hit(input hit_item_t h);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      hit_ch.valid = 1'b0;
      @(negedge clk);
    end
    hit_ch.valid = 1'b1;
    hit_ch.data  = h;
    @(posedge clk);
    while (!hit_ch.ready) @(posedge clk);
    pending_results.insert(pending_results.size(), cluster_predict(h));
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_drained();
    @(negedge clk);
    hit_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    res_item_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: %p", res_ch.data);
      end else begin
        want = pending_results.pop_front();
        if (res_ch.data.status != want.status ||
            res_ch.data.hit_count != want.hit_count ||
            res_ch.data.centroid_x != want.centroid_x ||
            res_ch.data.centroid_y != want.centroid_y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st %0d cnt %0d x %0d y %0d, got st %0d cnt %0d x %0d y %0d",
                     want.status, want.hit_count, want.centroid_x, want.centroid_y,
                     res_ch.data.status, res_ch.data.hit_count,
                     res_ch.data.centroid_x, res_ch.data.centroid_y);
        end
      end
    end
  end

  // Append before any start, then chamber, adjacency and truncation corners
  task automatic test_directed();
    send_hit(make_hit(REQ_APPEND, 8'd0, 0, 0, 16'sd5, -16'sd5));
    send_hit(make_hit(REQ_START, 8'd255, 127, 127, 16'sh7FFF, 16'sh8000));
    send_hit(make_hit(REQ_APPEND, 8'd254, 127, 127, 16'sd1, 16'sd1));
    send_hit(make_hit(REQ_APPEND, 8'd255, 126, 126, 16'sh7FFF, 16'sh8000));
    send_hit(make_hit(REQ_APPEND, 8'd255, 127, 127, 16'sh8000, 16'sh7FFF));
    send_hit(make_hit(REQ_APPEND, 8'd255, 124, 127, 16'sd0, 16'sd0));
    send_hit(make_hit(REQ_APPEND, 8'd255, 125, 127, -16'sd1, 16'sd1));
    send_hit(make_hit(REQ_START, 8'd0, 0, 0, -16'sd7, 16'sd7));
    send_hit(make_hit(REQ_APPEND, 8'd0, 1, 0, 16'sd0, 16'sd0));
    send_hit(make_hit(REQ_APPEND, 8'd0, 0, 2, 16'sd3, 16'sd3));
    send_hit(make_hit(REQ_APPEND, 8'd0, 2, 1, -16'sd2, 16'sd2));
    send_hit(make_hit(REQ_APPEND, 8'd128, 2, 1, 16'sd0, 16'sd0));
    send_hit(make_hit(REQ_START, 8'hAA, 7'h55, 7'h2A, 16'sh5555, 16'shAAAA));
    send_hit(make_hit(REQ_APPEND, 8'hAA, 7'h54, 7'h2B, 16'shAAAA, 16'sh5555));
    wait_drained();
  endtask

  // Fill the store along a row, then adjacent, distant and foreign appends
  task automatic test_store_full();
    send_hit(make_hit(REQ_START, 8'h5A, 0, 127, 16'sh7FFF, 16'sh8000));
    for (int k = 1; k < MAX_HITS; k++)
      send_hit(make_hit(REQ_APPEND, 8'h5A, k, 127, 16'sh7FFF, 16'sh8000));
    send_hit(make_hit(REQ_APPEND, 8'h5A, MAX_HITS, 126, 16'sd1, 16'sd1));
    send_hit(make_hit(REQ_APPEND, 8'h5A, 0, 127, 16'sd1, 16'sd1));
    send_hit(make_hit(REQ_APPEND, 8'h5A, MAX_HITS + 6, 127, 16'sd1, 16'sd1));
    send_hit(make_hit(REQ_APPEND, 8'hA5, 10, 127, 16'sd1, 16'sd1));
    wait_drained();
  endtask

  // Random clusters: mostly neighbor appends, with foreign, stray and restart noise
  task automatic test_random_clusters(input int n_items, input int gap_pct,
                                      input int stall_pct, input bit pause_mid);
    int               sent;
    int               len;
    int               pick;
    int               k;
    bit               paused;
    logic [CH_W-1:0]  ch;
    logic [31:0]      r;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      r  = $urandom();
      ch = ($urandom_range(7) == 0) ? {CH_W{r[8]}} : r[CH_W-1:0];
      send_hit(make_hit(REQ_START, ch, $urandom_range(127), $urandom_range(127),
                        rand_pos(), rand_pos()));
      sent++;
      len = ($urandom_range(9) == 0) ? $urandom_range(50, 75) : $urandom_range(1, 12);
      for (int n = 0; n < len && sent < n_items; n++) begin
        pick = $urandom_range(99);
        k    = (clu_count > 0) ? $urandom_range(clu_count - 1) : 0;
        if (pick < 80) begin
          send_hit(make_hit(REQ_APPEND, clu_chamber, near_pad(clu_pad_i[k]),
                            near_pad(clu_pad_j[k]), rand_pos(), rand_pos()));
        end else if (pick < 88) begin
          send_hit(make_hit(REQ_APPEND, clu_chamber ^ CH_W'($urandom_range(1, 255)),
                            near_pad(clu_pad_i[k]), near_pad(clu_pad_j[k]),
                            rand_pos(), rand_pos()));
        end else if (pick < 97) begin
          send_hit(make_hit(REQ_APPEND, clu_chamber, $urandom_range(127),
                            $urandom_range(127), rand_pos(), rand_pos()));
        end else begin
          send_hit(make_hit(REQ_START, clu_chamber, $urandom_range(127),
                            $urandom_range(127), rand_pos(), rand_pos()));
        end
        sent++;
        if (pause_mid && !paused && sent >= n_items / 2) begin
          paused = 1'b1;
          wait_drained();
        end
      end
    end
    wait_drained();
  endtask

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    hit_ch.valid   = 1'b0;
    hit_ch.data    = '0;
    res_ch.ready   = 1'b0;
    mismatches     = 0;
    cycle_count    = 0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    clu_chamber    = '0;
    clu_count      = 0;
    clu_sum_x      = 0;
    clu_sum_y      = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_store_full();
    test_random_clusters(PHASE_ITEMS, 0, 0, 1'b0);
    test_random_clusters(PHASE_ITEMS, 83, 0, 1'b1);
    test_random_clusters(PHASE_ITEMS, 0, 83, 1'b0);
    test_random_clusters(PHASE_ITEMS, 14, 14, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
